/* hdl/mtpc_pkg.sv */
// mtpc_pkg: shared types and constants of the motor tach position controller
// holds the word structs, action and mode codes and the per-motor state record
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mtpc_pkg;

    // fixed field widths
    localparam int unsigned ACTION_W = 3;
    localparam int unsigned MOTOR_W  = 2;
    localparam int unsigned SPEED_W  = 8;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned MODE_W   = 2;

    // speed limits of the motor driver
    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 8'sd100;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = -8'sd100;

    // input actions; the two spare codes behave like a read
    typedef enum logic [ACTION_W-1:0] {
        ACT_TACH  = 3'd0,
        ACT_STOP  = 3'd1,
        ACT_CONT  = 3'd2,
        ACT_ANGLE = 3'd3,
        ACT_TIME  = 3'd4,
        ACT_READ  = 3'd5
    } t_action;

    // motor modes
    typedef enum logic [MODE_W-1:0] {
        MODE_STOP  = 2'd0,
        MODE_CONT  = 2'd1,
        MODE_ANGLE = 2'd2,
        MODE_TIME  = 2'd3
    } t_mode;

    // input word
    typedef struct packed {
        t_action                    action;
        logic [MOTOR_W-1:0]         motor;
        logic signed [SPEED_W-1:0]  speed;
        logic [COUNT_W-1:0]         amount;
        logic                       brake_request;
        logic                       tach_level;
        logic                       dir_level;
        logic [COUNT_W-1:0]         now_ms;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [MOTOR_W-1:0]         motor_out;
        logic                       drive_valid;
        logic signed [SPEED_W-1:0]  drive_speed;
        logic                       drive_brake;
        logic signed [COUNT_W-1:0]  count_out;
        t_mode                      mode_out;
        logic                       error;
    } t_out_word;

    // per-motor state record
    typedef struct packed {
        t_mode                      mode;
        logic                       stop_brake;
        logic [COUNT_W-1:0]         tach_count;
        logic [COUNT_W-1:0]         target_value;
    } t_motor_state;

    // state of a motor after reset: stopped, brake on stop, zero count and target
    localparam t_motor_state ST_RESET = '{
        mode:         MODE_STOP,
        stop_brake:   1'b1,
        tach_count:   '0,
        target_value: '0
    };

endpackage : mtpc_pkg

`default_nettype wire

/* hdl/mtpc_state.sv */
// mtpc_state: per-motor state registers with one read and one write port
// the addressed motor is selected by index; an index past the motor count is flagged
// depends on mtpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mtpc_state
    import mtpc_pkg::*;
#(
    parameter int NUM_MOTORS = 3
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [MOTOR_W-1:0] i_motor,
    input  wire logic               i_wr_en,
    input  wire t_motor_state       i_wr_state,
    output t_motor_state            o_rd_state,
    output logic                    o_in_range
);

    t_motor_state r_st [NUM_MOTORS];

    // per-motor update, only the addressed entry is written
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_MOTORS; i++) begin
            if (!i_rst_n) begin
                r_st[i] <= ST_RESET;
            end else if (i_wr_en && (int'(i_motor) == i)) begin
                r_st[i] <= i_wr_state;
            end
        end
    end

    // read select over the motor entries
    always_comb begin
        o_rd_state = ST_RESET;
        for (int i = 0; i < NUM_MOTORS; i++) begin
            if (int'(i_motor) == i) begin
                o_rd_state = r_st[i];
            end
        end
    end

    assign o_in_range = (int'(i_motor) < NUM_MOTORS);

endmodule : mtpc_state

`default_nettype wire

/* hdl/mtpc_step.sv */
// mtpc_step: next state and result for one word applied to one motor
// pure combinational; tach counting, stop checks and command decode
// depends on mtpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mtpc_step
    import mtpc_pkg::*;
(
    input  wire t_in_word      i_word,
    input  wire logic          i_in_range,
    input  wire t_motor_state  i_cur,
    output t_motor_state       o_nxt,
    output t_out_word          o_result
);

    logic signed [SPEED_W-1:0] sat_speed;
    t_action                   act;
    logic [COUNT_W-1:0]        count_step;
    logic                      stop_hit;

    // speed saturation
    always_comb begin
        if (i_word.speed > SPEED_MAX) begin
            sat_speed = SPEED_MAX;
        end else if (i_word.speed < SPEED_MIN) begin
            sat_speed = SPEED_MIN;
        end else begin
            sat_speed = i_word.speed;
        end
    end

    // angle or time with zero speed acts as a stop
    always_comb begin
        act = i_word.action;
        if ((act inside {ACT_ANGLE, ACT_TIME}) && (i_word.speed == '0)) begin
            act = ACT_STOP;
        end
    end

    // tach step direction and stop condition
    assign count_step = (i_word.tach_level != i_word.dir_level)
                      ? i_cur.tach_count + COUNT_W'(1)
                      : i_cur.tach_count - COUNT_W'(1);

    assign stop_hit = ((i_cur.mode == MODE_ANGLE) && (count_step == i_cur.target_value))
                   || ((i_cur.mode == MODE_TIME)
                       && ($signed(i_word.now_ms) >= $signed(i_cur.target_value)));

    // action decode
    always_comb begin
        o_nxt              = i_cur;
        o_result           = '0;
        o_result.motor_out = i_word.motor;

        case (act)
            ACT_TACH: begin
                o_nxt.tach_count = count_step;
                if (stop_hit) begin
                    o_nxt.mode           = MODE_STOP;
                    o_result.drive_valid = 1'b1;
                    o_result.drive_brake = i_cur.stop_brake;
                end
            end
            ACT_STOP: begin
                o_nxt.mode           = MODE_STOP;
                o_result.drive_valid = 1'b1;
                o_result.drive_brake = i_word.brake_request;
            end
            ACT_CONT: begin
                o_nxt.mode           = MODE_CONT;
                o_result.drive_valid = 1'b1;
                o_result.drive_speed = sat_speed;
            end
            ACT_ANGLE: begin
                o_nxt.target_value   = i_word.speed[SPEED_W-1]
                                     ? i_cur.tach_count - i_word.amount
                                     : i_cur.tach_count + i_word.amount;
                o_nxt.stop_brake     = i_word.brake_request;
                o_nxt.mode           = MODE_ANGLE;
                o_result.drive_valid = 1'b1;
                o_result.drive_speed = sat_speed;
            end
            ACT_TIME: begin
                o_nxt.target_value   = i_word.now_ms + i_word.amount;
                o_nxt.stop_brake     = i_word.brake_request;
                o_nxt.mode           = MODE_TIME;
                o_result.drive_valid = 1'b1;
                o_result.drive_speed = sat_speed;
            end
            default: begin
            end
        endcase

        o_result.count_out = $signed(o_nxt.tach_count);
        o_result.mode_out  = o_nxt.mode;

        // bad motor index: no state change, error only
        if (!i_in_range) begin
            o_nxt              = i_cur;
            o_result           = '0;
            o_result.motor_out = i_word.motor;
            o_result.error     = 1'b1;
        end
    end

endmodule : mtpc_step

`default_nettype wire

/* hdl/motor_tach_position_controller_core.sv */
// motor_tach_position_controller_core: top level of the tach position controller
// input register, motor state file, step logic and result register
// depends on mtpc_pkg, mtpc_state, mtpc_step
//
// usage:
//  - input channel: i_in_valid / o_in_stall carry one t_in_word; a word is taken at
//    a rising edge with i_in_valid high and o_in_stall low
//  - output channel: o_out_valid / i_out_stall carry one t_out_word per input word,
//    in input order
//  - flow: a word taken into the input register is processed from there and its result
//    is registered in the result register, from which it is shown on the output side
//  - throughput: one word per cycle unless the output stalls; the per-motor read, count
//    step, compare and write back all happen in the same cycle between input and result
//    register, so a word for the same motor in the next cycle sees the updated state
//  - reset (i_rst_n low, synchronous): both stages empty, every motor stopped with
//    brake on stop, count and target zero
//  - stall: while the result register is full and i_out_stall is high, the result
//    holds; a word already in the input register waits and o_in_stall rises, so at
//    most two words are in flight
`timescale 1ns / 1ps
`default_nettype none

module motor_tach_position_controller_core
    import mtpc_pkg::*;
#(
    parameter int NUM_MOTORS = 3
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    logic          r_in_valid;
    t_in_word      r_in_word;
    logic          r_out_valid;
    t_out_word     r_out_word;

    logic          stage_fire;
    logic          in_range;
    t_motor_state  cur_state;
    t_motor_state  n_state;
    t_out_word     n_out_word;

    // pipeline advance
    assign stage_fire = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_word;
        end
    end

    // motor state file
    mtpc_state #(
        .NUM_MOTORS (NUM_MOTORS)
    ) u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_motor    (r_in_word.motor),
        .i_wr_en    (stage_fire && in_range),
        .i_wr_state (n_state),
        .o_rd_state (cur_state),
        .o_in_range (in_range)
    );

    // step logic
    mtpc_step u_step (
        .i_word     (r_in_word),
        .i_in_range (in_range),
        .i_cur      (cur_state),
        .o_nxt      (n_state),
        .o_result   (n_out_word)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_fire) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // checks
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_no_drive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.drive_valid)
            |-> (o_out_word.drive_speed == '0) && !o_out_word.drive_brake)
        else $error("drive fields set without a drive word");

    a_stop_zero_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.drive_valid && (o_out_word.mode_out == MODE_STOP))
            |-> (o_out_word.drive_speed == '0))
        else $error("stop drive word with nonzero speed");

    a_speed_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.drive_speed <= SPEED_MAX)
                     && (o_out_word.drive_speed >= SPEED_MIN))
        else $error("drive speed beyond limit");

    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.error)
            |-> !o_out_word.drive_valid && (o_out_word.count_out == '0))
        else $error("error word carries drive or count");

endmodule : motor_tach_position_controller_core

`default_nettype wire
